>>> rtl/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared widths, codes and payload types of the paged memory manager.
// ----------------------------------------------------------------------------
`default_nettype none

package pmm_pkg;

    localparam int OFFSET_BITS     = 10;
    localparam int PAGE_INDEX_BITS = 5;
    localparam int FRAME_BITS      = 10;
    localparam int FRAME_COUNT     = 1 << FRAME_BITS;
    localparam int PID_BITS        = 4;
    localparam int MAX_PROCESSES   = 1 << PID_BITS;
    localparam int VADDR_BITS      = 20;
    localparam int VPAGE_BITS      = VADDR_BITS - OFFSET_BITS;
    localparam int SLOT_BITS       = PID_BITS + VPAGE_BITS;
    localparam int STORE_BITS      = FRAME_BITS + OFFSET_BITS;
    localparam int BRK_BITS        = 21;
    localparam int SIZE_BITS       = 21;
    localparam int CNT_BITS        = FRAME_BITS + 1;
    localparam int PAGES_BITS      = SIZE_BITS - OFFSET_BITS + 1;

    localparam logic [BRK_BITS-1:0] BREAK_RESET = BRK_BITS'(1024);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNMAPPED  = 2'd1,
        ST_NO_MEMORY = 2'd2,
        ST_UNALIGNED = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [PID_BITS-1:0]   process_id;
        logic [VADDR_BITS-1:0] address;
        logic [SIZE_BITS-1:0]  size;
        logic [7:0]            write_data;
    } pmm_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VADDR_BITS-1:0] alloc_address;
        logic [7:0]            read_data;
    } pmm_out_t;

endpackage

`default_nettype wire

>>> rtl/pmm_ram.sv
// ----------------------------------------------------------------------------
// pmm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/paged_memory_manager_unit.sv
// ----------------------------------------------------------------------------
// paged_memory_manager_unit
// Per-process paged allocator over frame, page-map and byte memories.
// ----------------------------------------------------------------------------
// Read and write look up the page map, then touch the byte store; free walks the chain
// of frames; alloc counts the free frames, then claims them in a sweep of the owner table.
// One request at a time: the next is taken once the result beat has left, so the
// owner table sweep sets the pace. After reset a clearing pass zeroes the byte store,
// page map and owner table; no request or configuration write is taken meanwhile,
// and every break returns to 1024.
`default_nettype none

module paged_memory_manager_unit
    import pmm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pmm_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pmm_out_t              m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [BRK_BITS-1:0] cfg_data
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_MAPRD  = 12'b000000000100,
        S_MAPWT  = 12'b000000001000,
        S_BYTE   = 12'b000000010000,
        S_CNT    = 12'b000000100000,
        S_CNTW   = 12'b000001000000,
        S_CLAIM  = 12'b000010000000,
        S_CLAIMW = 12'b000100000000,
        S_FREE   = 12'b001000000000,
        S_FREEW  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg;
    pmm_in_t req_reg;
    pmm_out_t res_reg;
    logic [STORE_BITS-1:0] clr_reg;
    logic [CNT_BITS-1:0]  scan_reg, free_cnt_reg, k_reg;
    logic [FRAME_BITS-1:0] prev_reg, cur_reg;
    logic [CNT_BITS-1:0] del_reg, steps_reg;
    logic [PAGES_BITS-1:0] pages_reg;
    logic [BRK_BITS-1:0] brk_reg [0:MAX_PROCESSES-1];
    logic [BRK_BITS-1:0] bp_reg;
    logic m_valid_reg;

    // memory ports
    logic own_we, link_we, map_we, st_we;
    logic [FRAME_BITS-1:0] own_a, link_a;
    logic [PID_BITS-1:0] own_wd, own_rd;
    logic [FRAME_BITS:0] link_wd, link_rd;
    logic [SLOT_BITS-1:0] map_a;
    logic [FRAME_BITS:0] map_wd, map_rd;
    logic [STORE_BITS-1:0] st_a;
    logic [8:0] st_wd, st_rd;

    pmm_ram #(.AW(FRAME_BITS), .DW(PID_BITS)) u_own (.aclk, .we(own_we), .addr(own_a),
        .wdata(own_wd), .rdata(own_rd));
    pmm_ram #(.AW(FRAME_BITS), .DW(FRAME_BITS+1)) u_link (.aclk, .we(link_we),
        .addr(link_a), .wdata(link_wd), .rdata(link_rd));
    pmm_ram #(.AW(SLOT_BITS), .DW(FRAME_BITS+1)) u_map (.aclk, .we(map_we), .addr(map_a),
        .wdata(map_wd), .rdata(map_rd));
    // bit 8 marks a byte written since reset; unmarked bytes read as zero
    pmm_ram #(.AW(STORE_BITS), .DW(9)) u_store (.aclk, .we(st_we), .addr(st_a),
        .wdata(st_wd), .rdata(st_rd));

    logic [VPAGE_BITS-1:0] req_vpage;
    logic [SLOT_BITS-1:0] req_slot;
    logic [BRK_BITS-1:0] claim_va, free_va;
    logic [BRK_BITS+1:0] brk_end;
    logic [BRK_BITS+1:0] dec;
    logic free_hit;

    assign req_vpage = req_reg.address[VADDR_BITS-1:OFFSET_BITS];
    assign req_slot  = {req_reg.process_id, req_vpage};
    assign claim_va  = bp_reg + BRK_BITS'({k_reg, {OFFSET_BITS{1'b0}}});
    assign free_va   = BRK_BITS'(req_reg.address) + BRK_BITS'({del_reg, {OFFSET_BITS{1'b0}}});
    assign brk_end   = (BRK_BITS+2)'(bp_reg) + (BRK_BITS+2)'({pages_reg, {OFFSET_BITS{1'b0}}});
    assign dec       = (BRK_BITS+2)'({del_reg, {OFFSET_BITS{1'b0}}});
    assign free_hit  = (free_va[BRK_BITS-1:VADDR_BITS] == '0) && map_rd[FRAME_BITS];

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    // The breaks are only rewritten while no request is in progress.
    assign cfg_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = res_reg;

    always_comb begin
        own_we = 1'b0; own_a = scan_reg[FRAME_BITS-1:0]; own_wd = '0;
        link_we = 1'b0; link_a = prev_reg; link_wd = '0;
        map_we = 1'b0; map_a = req_slot; map_wd = '0;
        st_we = 1'b0;
        st_a = {map_rd[FRAME_BITS-1:0], req_reg.address[OFFSET_BITS-1:0]};
        st_wd = {1'b1, req_reg.write_data};
        case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1; map_a = clr_reg[SLOT_BITS-1:0];
                st_we = 1'b1; st_a = clr_reg; st_wd = '0;
                own_we = 1'b1; own_a = clr_reg[FRAME_BITS-1:0];
            end
            S_CLAIMW: begin
                if (own_rd == '0) begin
                    own_we = 1'b1; own_a = scan_reg[FRAME_BITS-1:0];
                    own_wd = req_reg.process_id;
                    if (k_reg != '0) begin
                        link_we = 1'b1; link_wd = {1'b0, scan_reg[FRAME_BITS-1:0]};
                    end
                    if (claim_va[BRK_BITS-1:VADDR_BITS] == '0) begin
                        map_we = 1'b1;
                        map_a = {req_reg.process_id, claim_va[VADDR_BITS-1:OFFSET_BITS]};
                        map_wd = {1'b1, scan_reg[FRAME_BITS-1:0]};
                    end
                end
            end
            S_OUT: begin
                if (req_reg.action == ACT_ALLOC && k_reg != '0) begin
                    link_we = 1'b1; link_wd = (FRAME_BITS+1)'(FRAME_COUNT);
                end
            end
            S_FREE: begin
                own_we = 1'b1; own_a = cur_reg; link_a = cur_reg;
                map_a = {req_reg.process_id, free_va[VADDR_BITS-1:OFFSET_BITS]};
            end
            S_FREEW: begin
                map_a = {req_reg.process_id, free_va[VADDR_BITS-1:OFFSET_BITS]};
                if (free_hit) begin
                    map_we = 1'b1;
                end
            end
            S_MAPWT: begin
                st_we = map_rd[FRAME_BITS] && req_reg.action == ACT_WRITE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < MAX_PROCESSES; p++) brk_reg[p] <= BREAK_RESET;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                for (int p = 0; p < MAX_PROCESSES; p++) brk_reg[p] <= cfg_data;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg <= s_data;
                        k_reg <= '0; del_reg <= '0; steps_reg <= '0;
                        scan_reg <= '0; free_cnt_reg <= '0;
                        bp_reg <= brk_reg[s_data.process_id];
                        pages_reg <= PAGES_BITS'(({1'b0, s_data.size}
                                     + (SIZE_BITS+1)'((1 << OFFSET_BITS) - 1)) >> OFFSET_BITS);
                        case (s_data.action)
                            ACT_ALLOC: begin
                                if (s_data.size == '0) begin
                                    res_reg <= '0; state_reg <= S_OUT;
                                end else if (s_data.process_id == '0) begin
                                    res_reg <= {ST_NO_MEMORY, {VADDR_BITS{1'b0}}, 8'd0};
                                    state_reg <= S_OUT;
                                end else begin
                                    res_reg <= '0; state_reg <= S_CNT;
                                end
                            end
                            ACT_FREE: begin
                                if (s_data.address[OFFSET_BITS-1:0] != '0) begin
                                    res_reg <= {ST_UNALIGNED, {VADDR_BITS{1'b0}}, 8'd0};
                                    state_reg <= S_OUT;
                                end else begin
                                    res_reg <= '0; state_reg <= S_MAPRD;
                                end
                            end
                            default: begin
                                res_reg <= '0; state_reg <= S_MAPRD;
                            end
                        endcase
                    end
                end
                S_MAPRD: state_reg <= S_MAPWT;
                S_MAPWT: begin
                    if (!map_rd[FRAME_BITS]) begin
                        res_reg.status <= ST_UNMAPPED; state_reg <= S_OUT;
                    end else if (req_reg.action == ACT_FREE) begin
                        cur_reg <= map_rd[FRAME_BITS-1:0]; state_reg <= S_FREE;
                    end else state_reg <= S_BYTE;
                end
                S_BYTE: state_reg <= S_OUT;
                S_CNT: state_reg <= S_CNTW;
                S_CNTW: begin
                    if (own_rd == '0) free_cnt_reg <= free_cnt_reg + 1'b1;
                    if (scan_reg == CNT_BITS'(FRAME_COUNT - 1)) begin
                        scan_reg <= '0;
                        if (CNT_BITS'(free_cnt_reg + (own_rd == '0)) < pages_reg ||
                            brk_end > (BRK_BITS+2)'(1 << VADDR_BITS)) begin
                            res_reg.status <= ST_NO_MEMORY; state_reg <= S_OUT;
                        end else state_reg <= S_CLAIM;
                    end else begin
                        scan_reg <= scan_reg + 1'b1; state_reg <= S_CNT;
                    end
                end
                S_CLAIM: state_reg <= S_CLAIMW;
                S_CLAIMW: begin
                    if (own_rd == '0) begin
                        prev_reg <= scan_reg[FRAME_BITS-1:0];
                        k_reg <= k_reg + 1'b1;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (PAGES_BITS'(k_reg + (own_rd == '0)) == pages_reg) begin
                        res_reg.alloc_address <= bp_reg[VADDR_BITS-1:0];
                        brk_reg[req_reg.process_id] <= BRK_BITS'(brk_end);
                        state_reg <= S_OUT;
                    end else state_reg <= S_CLAIM;
                end
                S_FREE: state_reg <= S_FREEW;
                S_FREEW: begin
                    if (free_hit) del_reg <= del_reg + 1'b1;
                    steps_reg <= steps_reg + 1'b1;
                    cur_reg <= link_rd[FRAME_BITS-1:0];
                    if (link_rd[FRAME_BITS] || steps_reg == CNT_BITS'(FRAME_COUNT - 1)) begin
                        if (free_hit) begin
                            brk_reg[req_reg.process_id] <=
                                (dec + (BRK_BITS+2)'(1 << OFFSET_BITS))
                                > (BRK_BITS+2)'(bp_reg) ? '0
                                : BRK_BITS'((BRK_BITS+2)'(bp_reg) - dec
                                  - (BRK_BITS+2)'(1 << OFFSET_BITS));
                        end else begin
                            brk_reg[req_reg.process_id] <= dec > (BRK_BITS+2)'(bp_reg) ? '0
                                : BRK_BITS'((BRK_BITS+2)'(bp_reg) - dec);
                        end
                        state_reg <= S_OUT;
                    end else state_reg <= S_FREE;
                end
                S_OUT: begin
                    if (req_reg.action == ACT_READ && res_reg.status == ST_DONE)
                        res_reg.read_data <= st_rd[8] ? st_rd[7:0] : 8'd0;
                    m_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("request taken during clearing pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready)
        else $error("request taken while a result waits");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> m_valid_reg)
        else $error("result not presented");

endmodule

`default_nettype wire

>>> verif/paged_memory_manager_unit_tb.sv
// ----------------------------------------------------------------------------
// paged_memory_manager_unit_tb
// Self-checking testbench for the paged memory manager. A scoreboard class
// keeps its own copy of the frame table, page map, breaks and byte store,
// predicts the answer to every accepted request and compares it with each
// result beat. Directed requests cover the corner cases, then random traffic
// built mostly from alloc, access and free sequences runs under several
// break settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_memory_manager_unit_tb;
    import pmm_pkg::*;

    localparam int PAGE_BYTES = 1 << OFFSET_BITS;
    localparam longint VSPACE = longint'(1) << VADDR_BITS;

    typedef struct {
        logic [PID_BITS-1:0] pid;
        int                  base;
        int                  bytes;
    } grant_t;

    class pmm_scoreboard;
        logic [PID_BITS-1:0]   owner [FRAME_COUNT];
        logic [FRAME_BITS:0]   link [FRAME_COUNT];
        bit                    mapped [1 << SLOT_BITS];
        logic [FRAME_BITS-1:0] map_frame [1 << SLOT_BITS];
        logic [BRK_BITS-1:0]   brk [MAX_PROCESSES];
        logic [7:0]            store [1 << STORE_BITS];
        pmm_out_t              awaited [$];
        grant_t                grants [$];
        int                    errors;

        function new();
            foreach (owner[f]) begin
                owner[f] = '0;
                link[f]  = '0;
            end
            foreach (mapped[s]) begin
                mapped[s]    = 1'b0;
                map_frame[s] = '0;
            end
            foreach (store[a]) store[a] = '0;
            set_break(BREAK_RESET);
            errors = 0;
        endfunction

        function void set_break(logic [BRK_BITS-1:0] value);
            foreach (brk[p]) brk[p] = value;
        endfunction

        function int slot_of(logic [PID_BITS-1:0] pid, longint vaddr);
            return int'(pid) * (1 << VPAGE_BITS) + int'(vaddr >> OFFSET_BITS);
        endfunction

        function void report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endfunction

        // Works out the answer to one accepted request and updates the state.
        function void note_request(pmm_in_t req);
            pmm_out_t res;
            longint   pages, bp, dec, va;
            int       free_cnt, k, prev, cur, del, steps, s;
            res = '0;
            res.status = ST_DONE;
            case (action_t'(req.action))
                ACT_ALLOC: begin
                    pages = (longint'(req.size) + PAGE_BYTES - 1) >> OFFSET_BITS;
                    if (req.size == 0) begin
                        res.status = ST_DONE;
                    end else if (req.process_id == 0) begin
                        res.status = ST_NO_MEMORY;
                    end else begin
                        free_cnt = 0;
                        foreach (owner[f]) if (owner[f] == 0) free_cnt++;
                        bp = longint'(brk[req.process_id]);
                        if (free_cnt < pages || bp + pages * PAGE_BYTES > VSPACE) begin
                            res.status = ST_NO_MEMORY;
                        end else begin
                            k = 0;
                            prev = 0;
                            for (int f = 0; f < FRAME_COUNT && k < pages; f++) begin
                                if (owner[f] == 0) begin
                                    owner[f] = req.process_id;
                                    if (k != 0) link[prev] = f[FRAME_BITS:0];
                                    s = slot_of(req.process_id, bp + k * PAGE_BYTES);
                                    mapped[s]    = 1'b1;
                                    map_frame[s] = f[FRAME_BITS-1:0];
                                    prev = f;
                                    k++;
                                end
                            end
                            link[prev] = FRAME_COUNT[FRAME_BITS:0];
                            brk[req.process_id] = BRK_BITS'(bp + pages * PAGE_BYTES);
                            res.alloc_address = bp[VADDR_BITS-1:0];
                            grants.push_back('{req.process_id, int'(bp),
                                               int'(pages * PAGE_BYTES)});
                        end
                    end
                end
                ACT_FREE: begin
                    s = slot_of(req.process_id, req.address);
                    if (req.address[OFFSET_BITS-1:0] != 0) begin
                        res.status = ST_UNALIGNED;
                    end else if (!mapped[s]) begin
                        res.status = ST_UNMAPPED;
                    end else begin
                        cur = map_frame[s];
                        del = 0;
                        steps = 0;
                        while (cur < FRAME_COUNT && steps < FRAME_COUNT) begin
                            owner[cur] = '0;
                            cur = link[cur];
                            va = longint'(req.address) + longint'(del) * PAGE_BYTES;
                            if (va < VSPACE && mapped[slot_of(req.process_id, va)]) begin
                                mapped[slot_of(req.process_id, va)] = 1'b0;
                                del++;
                            end
                            steps++;
                        end
                        bp  = longint'(brk[req.process_id]);
                        dec = longint'(del) * PAGE_BYTES;
                        brk[req.process_id] = (dec > bp) ? '0 : BRK_BITS'(bp - dec);
                        for (int i = grants.size() - 1; i >= 0; i--)
                            if (grants[i].pid == req.process_id &&
                                grants[i].base == int'(req.address))
                                grants.delete(i);
                    end
                end
                default: begin
                    s = slot_of(req.process_id, req.address);
                    if (!mapped[s]) begin
                        res.status = ST_UNMAPPED;
                    end else if (action_t'(req.action) == ACT_READ) begin
                        res.read_data = store[{map_frame[s], req.address[OFFSET_BITS-1:0]}];
                    end else begin
                        store[{map_frame[s], req.address[OFFSET_BITS-1:0]}] = req.write_data;
                    end
                end
            endcase
            awaited.push_back(res);
        endfunction

        function void check_result(pmm_out_t got);
            pmm_out_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result beat with nothing outstanding: %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.alloc_address !== want.alloc_address)
                report($sformatf("alloc_address %h, wanted %h",
                                 got.alloc_address, want.alloc_address));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, wanted %h", got.read_data, want.read_data));
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pmm_in_t             s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pmm_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BRK_BITS-1:0] cfg_data = '0;
    bit                  calm = 1'b0;

    pmm_scoreboard sb = new();

    paged_memory_manager_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic send_request(input pmm_in_t req);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
    endtask

    task automatic issue(input action_t act, input int pid, input int addr,
                         input int size, input int wdata);
        pmm_in_t req;
        req.action     = act;
        req.process_id = PID_BITS'(pid);
        req.address    = VADDR_BITS'(addr);
        req.size       = SIZE_BITS'(size);
        req.write_data = 8'(wdata);
        send_request(req);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Only written once the block has gone quiet.
    task automatic write_break(input logic [BRK_BITS-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_break(value);
    endtask

    // Mostly well-formed traffic: accesses land inside live grants and frees
    // hit their bases, with a share of stray addresses, sizes and ids.
    task automatic random_request();
        int     pick, size, pid, addr;
        grant_t g;
        bit     have;
        pick = $urandom_range(99);
        have = sb.grants.size() != 0;
        if (have) g = sb.grants[$urandom_range(sb.grants.size() - 1)];
        pid  = $urandom_range(1, MAX_PROCESSES - 1);
        addr = $urandom_range(VSPACE - 1);
        if (pick < 25) begin
            case ($urandom_range(9))
                0:       size = $urandom_range(1 << VADDR_BITS);
                1, 2:    size = $urandom_range(65536);
                3:       size = 0;
                default: size = $urandom_range(1, 3 * PAGE_BYTES);
            endcase
            if ($urandom_range(49) == 0) pid = 0;
            issue(ACT_ALLOC, pid, addr, size, $urandom_range(255));
        end else if (pick < 40) begin
            if (have && $urandom_range(9) < 8) issue(ACT_FREE, g.pid, g.base, 0, 0);
            else issue(ACT_FREE, pid, addr & ~(PAGE_BYTES - 1) | ($urandom_range(3) == 0 ?
                       $urandom_range(PAGE_BYTES - 1) : 0), 0, 0);
        end else begin
            if (have && $urandom_range(9) < 8) begin
                pid  = g.pid;
                addr = g.base + $urandom_range(g.bytes - 1);
            end
            issue(($urandom_range(1) != 0) ? ACT_WRITE : ACT_READ, pid, addr,
                  $urandom(), $urandom_range(255));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        issue(ACT_ALLOC, 1, 0, 0, 0);
        issue(ACT_ALLOC, 0, 0, 100, 0);
        issue(ACT_ALLOC, 1, 0, 1, 0);
        issue(ACT_WRITE, 1, 1029, 0, 255);
        issue(ACT_READ, 1, 1029, 0, 0);
        issue(ACT_READ, 1, 1030, 0, 0);
        issue(ACT_READ, 2, 1029, 0, 0);
        issue(ACT_READ, 1, VSPACE - 1, 0, 0);
        issue(ACT_FREE, 1, 1025, 0, 0);
        issue(ACT_FREE, 1, 4096, 0, 0);
        issue(ACT_ALLOC, 15, 0, 1 << VADDR_BITS, 0);
        issue(ACT_ALLOC, 2, 0, 3000, 0);
        issue(ACT_WRITE, 2, 1024 + 3 * PAGE_BYTES - 1, 0, 8'ha5);
        issue(ACT_READ, 2, 1024 + 3 * PAGE_BYTES - 1, 0, 0);
        issue(ACT_FREE, 2, 1024, 0, 0);
        issue(ACT_READ, 2, 1024, 0, 0);
        // Takes every remaining frame, so the next request runs dry.
        issue(ACT_ALLOC, 3, 0, (1 << VADDR_BITS) - PAGE_BYTES, 0);
        issue(ACT_ALLOC, 4, 0, 1, 0);
        issue(ACT_WRITE, 3, VSPACE - 1, 0, 8'h5a);
        issue(ACT_READ, 3, VSPACE - 1, 0, 0);
        issue(ACT_FREE, 3, 1024, 0, 0);
        issue(ACT_ALLOC, 5, 0, 2048, 0);
        issue(ACT_FREE, 5, 2048, 0, 0);
        issue(ACT_ALLOC, 5, 0, 1024, 0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_break('0);
                2: write_break(BRK_BITS'($urandom_range(1 << VADDR_BITS)));
                3: write_break(BRK_BITS'(1 << VADDR_BITS));
                4: write_break(BRK_BITS'($urandom_range(64) * PAGE_BYTES));
                default: ;
            endcase
            for (int n = 0; n < (phase == 3 ? 40 : 135); n++) begin
                calm = (phase == 1 && n >= 30 && n < 110);
                random_request();
            end
            calm = 1'b0;
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(8 * 20000000);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/pmm_pkg.sv
rtl/pmm_ram.sv
rtl/paged_memory_manager_unit.sv
verif/paged_memory_manager_unit_tb.sv
